/* design/mtrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_pkg
// Shared types and constants of the memory type range lookup block.
// ----------------------------------------------------------------------------
package mtrr_pkg;

   localparam int ADDR_W         = 52;
   localparam int DATA_W         = 64;
   localparam int IDX_W_IN       = 4;
   localparam int TYPE_W         = 8;
   localparam int CNT_W          = 5;   // holds range_count and the walk position
   localparam int FIXED_WORDS    = 11;
   localparam int VAR_RANGES_DEF = 8;
   localparam int BND_W          = 21;  // fixed-region boundaries stay at or below 1 MiB

   localparam logic [1:0] MODE_LOOKUP   = 2'd0;
   localparam logic [1:0] MODE_WR_FIXED = 2'd1;
   localparam logic [1:0] MODE_WR_BASE  = 2'd2;
   localparam logic [1:0] MODE_WR_MASK  = 2'd3;

   localparam logic CSR_DEFAULT_TYPE = 1'b0;
   localparam logic CSR_RANGE_COUNT  = 1'b1;

   localparam logic [ADDR_W-1:0] LIMIT_64K = 52'h80000;
   localparam logic [ADDR_W-1:0] LIMIT_16K = 52'hC0000;
   localparam logic [ADDR_W-1:0] LIMIT_4K  = 52'h100000;

   localparam int MASK_ENABLE_BIT = 11;
   localparam int PAGE_SHIFT      = 12;
   localparam int PAGE_W          = DATA_W - PAGE_SHIFT;

   typedef enum logic [2:0] {
      K_NOP,
      K_WR_FIXED,
      K_WR_BASE,
      K_WR_MASK,
      K_LOOK_FIXED,
      K_LOOK_VAR
   } kind_type;

   // one queued item; a fixed lookup carries its word number in index
   // and its region end in data
   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     address;
      logic [IDX_W_IN-1:0]   index;
      logic [2:0]            sel;
      logic [DATA_W-1:0]     data;
   } op_type;

endpackage

/* design/mtrr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_if
// Valid/ready channels for lookup and write items and for lookup results.
// ----------------------------------------------------------------------------
interface mtrr_req_if import mtrr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [ADDR_W-1:0]     address;
   logic [IDX_W_IN-1:0]   reg_index;
   logic [DATA_W-1:0]     write_data;

   modport source (output valid, mode, address, reg_index, write_data, input ready);
   modport sink   (input valid, mode, address, reg_index, write_data, output ready);
endinterface

interface mtrr_rsp_if import mtrr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TYPE_W-1:0]     mem_type;
   logic [DATA_W-1:0]     next_boundary;

   modport source (output valid, mem_type, next_boundary, input ready);
   modport sink   (input valid, mem_type, next_boundary, output ready);
endinterface

/* design/mtrr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_front
// Accepts items, sorts them into operations, resolves the fixed-region
// word, byte and region end, and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module mtrr_front import mtrr_pkg::*; #(
   parameter int VAR_RANGES = VAR_RANGES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   mtrr_req_if.sink        req,
   output logic            q_valid,
   output op_type          q_entry,
   input  logic            q_pop
);

   op_type               op_in;
   op_type               entry_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push;
   logic [BND_W-1:0]     bnd_in;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      op_in         = '0;
      op_in.kind    = K_NOP;
      op_in.address = req.address;
      op_in.index   = req.reg_index;
      op_in.data    = req.write_data;
      bnd_in        = '0;
      case (req.mode)
         MODE_LOOKUP: begin
            if (req.address < LIMIT_64K) begin
               op_in.kind  = K_LOOK_FIXED;
               op_in.index = 4'd0;
               op_in.sel   = req.address[18:16];
               bnd_in      = BND_W'(req.address[19:0] | 20'hFFFF) + 21'd1;
            end else if (req.address < LIMIT_16K) begin
               op_in.kind  = K_LOOK_FIXED;
               op_in.index = 4'd1 + {3'b000, req.address[17]};
               op_in.sel   = req.address[16:14];
               bnd_in      = BND_W'(req.address[19:0] | 20'h3FFF) + 21'd1;
            end else if (req.address < LIMIT_4K) begin
               op_in.kind  = K_LOOK_FIXED;
               op_in.index = 4'd3 + {1'b0, req.address[17:15]};
               op_in.sel   = req.address[14:12];
               bnd_in      = BND_W'(req.address[19:0] | 20'h0FFF) + 21'd1;
            end else begin
               op_in.kind  = K_LOOK_VAR;
            end
            op_in.data = DATA_W'(bnd_in);
         end
         MODE_WR_FIXED: begin
            if (32'(req.reg_index) < FIXED_WORDS) op_in.kind = K_WR_FIXED;
         end
         MODE_WR_BASE: begin
            if (32'(req.reg_index) < VAR_RANGES) op_in.kind = K_WR_BASE;
         end
         MODE_WR_MASK: begin
            if (32'(req.reg_index) < VAR_RANGES) op_in.kind = K_WR_MASK;
         end
         default: op_in.kind = K_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= op_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push)  wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, q_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* design/mtrr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_back
// Holds the fixed words and variable range pairs, applies writes and
// resolves lookups: fixed regions in one step, variable ranges by a
// three-stage walk over one pair per cycle. Results leave through an
// output register.
// ----------------------------------------------------------------------------
module mtrr_back import mtrr_pkg::*; #(
   parameter int VAR_RANGES = VAR_RANGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [TYPE_W-1:0]   default_type,
   input  logic [3:0]          range_count,
   input  logic                q_valid,
   input  op_type              q_entry,
   output logic                q_pop,
   mtrr_rsp_if.source          rsp
);

   // pairs beyond sixteen can never be written through a four-bit index
   localparam int STORED = (VAR_RANGES < 16) ? VAR_RANGES : 16;
   localparam int IDX_W  = (STORED > 1) ? $clog2(STORED) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_type;

   state_type              state_ff;
   logic [DATA_W-1:0]      fixed_ff [FIXED_WORDS];
   logic [DATA_W-1:0]      base_ff  [STORED];
   logic [DATA_W-1:0]      mask_ff  [STORED];

   logic [ADDR_W-1:0]      addr_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       used_ff;
   logic [CNT_W-1:0]       used_in;

   logic                   s1_vld_ff;
   logic [DATA_W-1:0]      s1_base_ff;
   logic [DATA_W-1:0]      s1_mask_ff;

   logic                   s2_vld_ff;
   logic                   s2_en_ff;
   logic                   s2_below_ff;
   logic                   s2_match_ff;
   logic [PAGE_W-1:0]      s2_page_ff;
   logic [PAGE_W-1:0]      s2_size_ff;
   logic [TYPE_W-1:0]      s2_type_ff;

   logic [DATA_W-1:0]      nxt_ff;
   logic [TYPE_W-1:0]      typ_ff;
   logic                   hit_ff;

   logic                   out_vld_ff;
   logic [TYPE_W-1:0]      out_type_ff;
   logic [DATA_W-1:0]      out_next_ff;

   // stage 1 terms
   logic [PAGE_W-1:0]      addr_page;
   logic [PAGE_W-1:0]      base_page;
   logic [PAGE_W-1:0]      hi_in;
   logic [PAGE_W-1:0]      size_in;
   logic                   below_in;
   logic                   match_in;

   // stage 2 terms
   logic [PAGE_W:0]        end_page;
   logic                   end_ok;
   logic [DATA_W-1:0]      cand;
   logic                   cand_ok;
   logic                   take_next;
   logic                   take_type;

   logic [TYPE_W-1:0]      fixed_byte;
   logic                   wr_go;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign wr_go = q_pop;

   assign rsp.valid         = out_vld_ff;
   assign rsp.mem_type      = out_type_ff;
   assign rsp.next_boundary = out_next_ff;

   assign fixed_byte = fixed_ff[q_entry.index][q_entry.sel * 8 +: 8];
   assign used_in    = ({1'b0, range_count} > CNT_W'(STORED)) ? CNT_W'(STORED)
                                                              : {1'b0, range_count};

   assign addr_page = PAGE_W'(addr_ff[ADDR_W-1:PAGE_SHIFT]);
   assign base_page = s1_base_ff[DATA_W-1:PAGE_SHIFT];
   assign hi_in     = s1_mask_ff[DATA_W-1:PAGE_SHIFT];
   assign size_in   = hi_in & (~hi_in + {{(PAGE_W-1){1'b0}}, 1'b1});
   assign below_in  = addr_page < base_page;
   assign match_in  = ((addr_page ^ base_page) & hi_in) == '0;

   assign end_page  = {1'b0, s2_page_ff} + {1'b0, s2_size_ff};
   // no end when the mask has no page bits or the end wraps past 64 bits
   assign end_ok    = (s2_size_ff != '0) && !end_page[PAGE_W];
   assign cand      = s2_below_ff ? {s2_page_ff, {PAGE_SHIFT{1'b0}}}
                                  : {end_page[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
   assign cand_ok   = s2_below_ff || (s2_match_ff && end_ok);
   assign take_next = s2_vld_ff && s2_en_ff && cand_ok && (cand < nxt_ff);
   assign take_type = s2_vld_ff && s2_en_ff && !s2_below_ff && s2_match_ff
                      && (!hit_ff || (s2_type_ff < typ_ff));

   // register files
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FIXED_WORDS; i++) fixed_ff[i] <= '0;
         for (int i = 0; i < STORED; i++) begin
            base_ff[i] <= '0;
            mask_ff[i] <= '0;
         end
      end else if (wr_go) begin
         case (q_entry.kind)
            K_WR_FIXED: fixed_ff[q_entry.index] <= q_entry.data;
            K_WR_BASE:  base_ff[q_entry.index[IDX_W-1:0]] <= q_entry.data;
            K_WR_MASK:  mask_ff[q_entry.index[IDX_W-1:0]] <= q_entry.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         cnt_ff     <= '0;
         used_ff    <= '0;
      end else begin
         // in the finishing state the output register is reloaded instead
         if (out_vld_ff && rsp.ready && state_ff != ST_FIN) out_vld_ff <= 1'b0;

         s2_vld_ff   <= s1_vld_ff;
         s2_en_ff    <= s1_mask_ff[MASK_ENABLE_BIT];
         s2_below_ff <= below_in;
         s2_match_ff <= match_in;
         s2_page_ff  <= base_page;
         s2_size_ff  <= size_in;
         s2_type_ff  <= s1_base_ff[TYPE_W-1:0];

         if (take_next) nxt_ff <= cand;
         if (take_type) begin
            typ_ff <= s2_type_ff;
            hit_ff <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  case (q_entry.kind)
                     K_LOOK_FIXED: begin
                        typ_ff   <= fixed_byte;
                        hit_ff   <= 1'b1;
                        nxt_ff   <= q_entry.data;
                        state_ff <= ST_FIN;
                     end
                     K_LOOK_VAR: begin
                        addr_ff  <= q_entry.address;
                        cnt_ff   <= '0;
                        used_ff  <= used_in;
                        typ_ff   <= '0;
                        hit_ff   <= 1'b0;
                        nxt_ff   <= '1;
                        state_ff <= ST_WALK;
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               if (cnt_ff < used_ff) begin
                  s1_vld_ff  <= 1'b1;
                  s1_base_ff <= base_ff[cnt_ff[IDX_W-1:0]];
                  s1_mask_ff <= mask_ff[cnt_ff[IDX_W-1:0]];
                  cnt_ff     <= cnt_ff + CNT_W'(1);
               end else begin
                  s1_vld_ff <= 1'b0;
                  if (!s1_vld_ff && !s2_vld_ff) state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!out_vld_ff || rsp.ready) begin
                  out_vld_ff  <= 1'b1;
                  out_type_ff <= hit_ff ? typ_ff : default_type;
                  out_next_ff <= nxt_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* design/mtrr_memory_type_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_memory_type_lookup
// Memory type lookup over fixed and variable range registers.
// ----------------------------------------------------------------------------
// Items enter on req_ch and land in a two-entry queue, so the front keeps
// taking items while the back works or a result waits on rsp_ch. The back
// takes one item at a time. A write is applied as it leaves the queue and
// gives no result. A lookup below 1 MiB is resolved as it leaves the queue
// and passes through the finishing state to the output register. A lookup
// at or above 1 MiB walks the first min(range_count, VAR_RANGES) variable
// pairs through a three-stage pipeline reading one pair per cycle from the
// register file, then passes through the finishing state to the output
// register. A result still waiting on rsp_ch holds the back in its last
// step until it leaves. Writes to default_type and range_count go through
// csr_* and are meant for when the block is idle.
// ----------------------------------------------------------------------------
module mtrr_memory_type_lookup import mtrr_pkg::*; #(
   parameter int VAR_RANGES = VAR_RANGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   mtrr_req_if.sink           req_ch,
   mtrr_rsp_if.source         rsp_ch,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [TYPE_W-1:0]  csr_wdata
);

   logic [TYPE_W-1:0]  default_type_ff;
   logic [3:0]         range_count_ff;
   logic               q_valid;
   op_type             q_entry;
   logic               q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_type_ff <= '0;
         range_count_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEFAULT_TYPE: default_type_ff <= csr_wdata;
            CSR_RANGE_COUNT:  range_count_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   mtrr_front #(
      .VAR_RANGES (VAR_RANGES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   mtrr_back #(
      .VAR_RANGES (VAR_RANGES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .default_type (default_type_ff),
      .range_count  (range_count_ff),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .rsp          (rsp_ch)
   );

endmodule

/* tb/sv/mtrr_memory_type_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_memory_type_lookup_test
// Self-checking bench for the memory type range lookup block.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver on req_ch. Every accepted
// write updates a local copy of the fixed words and variable base/mask pairs
// (the two registers are copied as they are written); each lookup queues
// the memory type and next boundary it should return. A clocked monitor on
// rsp_ch checks each result against the oldest queued lookup. The run starts
// with a short directed part, then goes through phases of random items, each
// with its own register settings and a fresh set of well-formed ranges.
// ----------------------------------------------------------------------------
module mtrr_memory_type_lookup_test;
   import mtrr_pkg::*;

   localparam int NUM_RANGES    = VAR_RANGES_DEF;
   localparam int PHASE_ITEMS   = 125;
   localparam int NUM_PHASES    = 6;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 50;

   typedef struct {
      logic [1:0]          mode;
      logic [ADDR_W-1:0]   address;
      logic [IDX_W_IN-1:0] reg_index;
      logic [DATA_W-1:0]   write_data;
   } request_type;

   typedef struct {
      logic [TYPE_W-1:0] mem_type;
      logic [DATA_W-1:0] next_boundary;
   } lookup_result_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [TYPE_W-1:0]   csr_wdata;

   mtrr_req_if req_bus ();
   mtrr_rsp_if rsp_bus ();

   mtrr_memory_type_lookup #(
      .VAR_RANGES (NUM_RANGES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the block's registers
   logic [DATA_W-1:0]   model_fixed [FIXED_WORDS];
   logic [DATA_W-1:0]   model_base [NUM_RANGES];
   logic [DATA_W-1:0]   model_mask [NUM_RANGES];
   logic [TYPE_W-1:0]   model_default;
   logic [3:0]          model_count;

   request_type         pending_items[$];
   lookup_result_type   expected_lookups[$];

   // stimulus-side view of the ranges last programmed, for aiming lookups
   logic [DATA_W-1:0]   range_lo [NUM_RANGES];
   logic [DATA_W-1:0]   range_hi [NUM_RANGES];

   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  req_gap;
   int                  rsp_stall;
   int                  hold_left;
   logic                hold_start;
   logic                bursts_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic lookup_result_type resolve_address(logic [ADDR_W-1:0] addr);
      lookup_result_type res;
      logic [63:0]    a;
      logic [63:0]    shift;
      logic [63:0]    mask;
      logic [63:0]    rb;
      logic [63:0]    base;
      logic [63:0]    hi;
      logic [63:0]    stop;
      logic [7:0]     best;
      int             w;
      int             used;
      bit             hit;
      a = 64'(addr);
      res.mem_type = '0;
      res.next_boundary = '1;
      w = -1;
      shift = '0;
      if (addr < LIMIT_64K) begin
         w = 0;
         shift = a >> 13;
         res.next_boundary = (a | 64'hffff) + 64'd1;
      end else if (addr < LIMIT_16K) begin
         w = 1 + int'(a[17]);
         shift = a >> 11;
         res.next_boundary = (a | 64'h3fff) + 64'd1;
      end else if (addr < LIMIT_4K) begin
         w = 3 + int'(a[17:15]);
         shift = a >> 9;
         res.next_boundary = (a | 64'hfff) + 64'd1;
      end
      if (w >= 0) begin
         res.mem_type = 8'(model_fixed[w] >> (shift & 64'h38));
      end else begin
         hit = 1'b0;
         best = '0;
         used = (model_count < NUM_RANGES) ? int'(model_count) : NUM_RANGES;
         for (int i = 0; i < used; i++) begin
            mask = model_mask[i];
            rb = model_base[i];
            base = rb & ~64'hfff;
            if (mask[MASK_ENABLE_BIT]) begin
               if (a < base) begin
                  if (base < res.next_boundary) res.next_boundary = base;
               end else if ((((a ^ rb) & mask) >> PAGE_SHIFT) == 64'd0) begin
                  hi = mask & ~64'hfff;
                  if (hi != 64'd0) begin
                     stop = base + (hi & (~hi + 64'd1));
                     // an end that wraps past 64 bits adds no boundary
                     if (stop > base && stop < res.next_boundary) res.next_boundary = stop;
                  end
                  if (!hit || rb[7:0] < best) best = rb[7:0];
                  hit = 1'b1;
               end
            end
         end
         res.mem_type = hit ? best : model_default;
      end
      return res;
   endfunction

   task automatic apply_request(request_type r);
      case (r.mode)
         MODE_LOOKUP: begin
            expected_lookups.push_back(resolve_address(r.address));
         end
         MODE_WR_FIXED: begin
            if (r.reg_index < FIXED_WORDS) model_fixed[r.reg_index] = r.write_data;
         end
         MODE_WR_BASE: begin
            if (r.reg_index < NUM_RANGES) model_base[r.reg_index] = r.write_data;
         end
         default: begin
            if (r.reg_index < NUM_RANGES) model_mask[r.reg_index] = r.write_data;
         end
      endcase
   endtask

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $time, what);
   endtask

   task automatic push_write(logic [1:0] mode, int idx, logic [63:0] data);
      request_type r;
      r.mode = mode;
      r.address = ADDR_W'(random_word());
      r.reg_index = IDX_W_IN'(idx);
      r.write_data = data;
      pending_items.push_back(r);
   endtask

   task automatic push_lookup(logic [63:0] addr);
      request_type r;
      r.mode = MODE_LOOKUP;
      r.address = addr[ADDR_W-1:0];
      r.reg_index = IDX_W_IN'($urandom_range(0, 15));
      r.write_data = random_word();
      pending_items.push_back(r);
   endtask

   // a naturally aligned power-of-two range, now and then disabled or unbounded
   task automatic program_range(int i);
      int          k;
      int          span;
      logic [63:0] size;
      logic [63:0] base;
      logic [63:0] mask;
      logic [63:0] rb;
      logic [7:0]  kind;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 51) : $urandom_range(12, 30);
      size = 64'd1 << k;
      span = k + $urandom_range(0, 3);
      if (span > ADDR_W) span = ADDR_W;
      base = random_word() & ((64'd1 << span) - 64'd1) & ~(size - 64'd1);
      kind = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      rb = base | 64'(kind) | (64'($urandom_range(0, 15)) << 8);
      mask = ~(size - 64'd1);
      if ($urandom_range(0, 1) == 1) mask = mask & 64'h000F_FFFF_FFFF_FFFF;
      mask = (mask & ~64'hfff) | 64'($urandom_range(0, 16'h7ff)) | 64'h800;
      if ($urandom_range(0, 9) == 0) mask[MASK_ENABLE_BIT] = 1'b0;
      if ($urandom_range(0, 19) == 0) mask = mask & 64'hfff;
      push_write(MODE_WR_BASE, i, rb);
      push_write(MODE_WR_MASK, i, mask);
      range_lo[i] = base;
      range_hi[i] = base + size;
   endtask

   task automatic push_random_lookup();
      logic [63:0] a;
      int          i;
      case ($urandom_range(0, 9))
         0, 1: a = 64'($urandom_range(0, 32'hFFFFF));
         2: a = random_word();
         3: a = 64'h100000 + 64'($urandom_range(0, 32'hFFFFF));
         default: begin
            i = $urandom_range(0, NUM_RANGES - 1);
            a = ($urandom_range(0, 1) == 1) ? range_lo[i] : range_hi[i];
            case ($urandom_range(0, 3))
               0: a = a - 64'd1;
               1: a = a;
               2: a = a + 64'($urandom_range(0, 32'hFFFF));
               default: a = a - 64'($urandom_range(1, 4096));
            endcase
         end
      endcase
      push_lookup(a);
   endtask

   task automatic fill_phase(int count);
      int          made;
      int          pick;
      int          idx;
      logic [1:0]  mode;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            program_range($urandom_range(0, NUM_RANGES - 1));
            made += 2;
         end else if (pick < 22) begin
            push_write(MODE_WR_FIXED, $urandom_range(0, FIXED_WORDS - 1), random_word());
            made++;
         end else if (pick < 27) begin
            // raw write: any index, any data
            mode = 2'($urandom_range(1, 3));
            idx = $urandom_range(0, 15);
            push_write(mode, idx, random_word());
            if ((mode == MODE_WR_FIXED) ? (idx < FIXED_WORDS) : (idx < NUM_RANGES)) made++;
         end else begin
            push_random_lookup();
            made++;
         end
      end
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DEFAULT_TYPE) model_default = value;
      else model_count = value[3:0];
   endtask

   task automatic wait_idle();
      // checked between edges, once the driver and monitor have settled
      while (pending_items.size() != 0 || req_bus.valid || expected_lookups.size() != 0)
         @(negedge clock);
      // writes give no result and may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request side
   always @(posedge clock) begin : request_driver
      request_type took;
      request_type nxt;
      logic        fire;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.mode <= MODE_LOOKUP;
         req_bus.address <= '0;
         req_bus.reg_index <= '0;
         req_bus.write_data <= '0;
         req_gap <= 0;
      end else begin
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            took.mode = req_bus.mode;
            took.address = req_bus.address;
            took.reg_index = req_bus.reg_index;
            took.write_data = req_bus.write_data;
            apply_request(took);
         end
         if (req_bus.valid && !fire) begin
            // item stays on offer
         end else if (fire && bursts_on && $urandom_range(0, 7) == 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= $urandom_range(0, 14);
         end else if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_items.size() != 0) begin
            nxt = pending_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.mode <= nxt.mode;
            req_bus.address <= nxt.address;
            req_bus.reg_index <= nxt.reg_index;
            req_bus.write_data <= nxt.write_data;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side
   always @(posedge clock) begin : result_monitor
      lookup_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch($sformatf("unexpected result: type %0h next %0h",
                                         rsp_bus.mem_type, rsp_bus.next_boundary));
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_bus.mem_type !== want.mem_type)
                  report_mismatch($sformatf("mem_type %0h, expected %0h",
                                            rsp_bus.mem_type, want.mem_type));
               if (rsp_bus.next_boundary !== want.next_boundary)
                  report_mismatch($sformatf("next_boundary %0h, expected %0h",
                                            rsp_bus.next_boundary, want.next_boundary));
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall <= $urandom_range(0, 14);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [7:0] dflt;
      logic [7:0] cnt;
      model_default = '0;
      model_count = '0;
      for (int i = 0; i < FIXED_WORDS; i++) model_fixed[i] = '0;
      for (int i = 0; i < NUM_RANGES; i++) begin
         model_base[i] = '0;
         model_mask[i] = '0;
         range_lo[i] = 64'h100000;
         range_hi[i] = 64'h200000;
      end
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_DEFAULT_TYPE;
      csr_wdata <= '0;
      hold_start <= 1'b0;
      bursts_on <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // state straight out of reset
      push_lookup(64'h0);
      push_lookup(64'h100000);
      wait_idle();

      write_csr(CSR_DEFAULT_TYPE, 8'h5A);
      write_csr(CSR_RANGE_COUNT, 8'd8);
      for (int w = 0; w < FIXED_WORDS; w++) begin
         if (w <= 3 || w == FIXED_WORDS - 1)
            push_write(MODE_WR_FIXED, w, 64'h0706050403020100 + 64'(w) * 64'h1010101010101010);
      end
      push_write(MODE_WR_FIXED, 15, random_word());          // out of range, ignored
      push_lookup(64'h0);
      push_lookup(64'h7FFFF);
      push_lookup(64'h80000);
      push_lookup(64'hBFFFF);
      push_lookup(64'hC0000);
      push_lookup(64'hFFFFF);
      // 1 MiB..2 MiB, type 6
      push_write(MODE_WR_BASE, 0, 64'h100006);
      push_write(MODE_WR_MASK, 0, 64'h000F_FFFF_FFF0_0800);
      // enabled with no size bits: never ends, lower type wins the overlap
      push_write(MODE_WR_BASE, 1, 64'h180002);
      push_write(MODE_WR_MASK, 1, 64'h800);
      // enable bit clear
      push_write(MODE_WR_BASE, 2, 64'h400000);
      push_write(MODE_WR_MASK, 2, 64'hFFFF_FFFF_FFC0_0000);
      push_write(MODE_WR_BASE, NUM_RANGES, random_word());   // out of range, ignored
      push_lookup(64'h100000);
      push_lookup(64'h1FFFFF);
      push_lookup(64'h200000);
      push_lookup(64'h000F_FFFF_FFFF_FFFF);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin dflt = 8'hFF; cnt = 8'h00; end
            1: begin dflt = 8'h00; cnt = 8'hF8; end
            2: begin dflt = 8'($urandom_range(0, 255)); cnt = 8'h0F; end
            3: begin dflt = 8'($urandom_range(0, 255)); cnt = 8'($urandom_range(1, 7)); end
            4: begin dflt = 8'($urandom_range(0, 255)); cnt = 8'($urandom_range(0, 255)); end
            default: begin dflt = 8'h80; cnt = 8'h08; end
         endcase
         write_csr(CSR_DEFAULT_TYPE, dflt);
         write_csr(CSR_RANGE_COUNT, cnt);
         bursts_on <= (ph != 3 && ph != NUM_PHASES - 1);
         for (int i = 0; i < NUM_RANGES; i++) program_range(i);
         fill_phase(PHASE_ITEMS - 2 * NUM_RANGES);
         if (ph == 1) begin
            // receiver stops while items keep coming
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
